// ===== sv/mpq_pkg.sv =====
package mpq_pkg;

	// Queue depth and field widths
	localparam int CAPACITY = 64;
	localparam int KEY_W    = 32;
	localparam int OCC_W    = 7;

	// Key returned by a delete-minimum on an empty queue
	localparam logic signed [KEY_W-1:0] EMPTY_DELETE_KEY = 32'sh8000_0001;

	// Operation codes on func
	typedef enum logic [1:0] {
		OP_INSERT  = 2'd0,
		OP_DELMIN  = 2'd1,
		OP_FINDMIN = 2'd2,
		OP_NOP     = 2'd3
	} func_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_RSVD  = 2'd3
	} status_t;

	// Broadcast command to every cell of the row
	typedef enum logic [1:0] {
		CELL_HOLD = 2'd0,
		CELL_PUSH = 2'd1,
		CELL_POP  = 2'd2,
		CELL_IDLE = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t               op;
		logic signed [KEY_W-1:0] key;
	} cell_ctl_t;

	// What a cell shows its neighbours
	typedef struct packed {
		logic                    valid;
		logic signed [KEY_W-1:0] val;
		logic                    ins;   // new key belongs at or before this cell
	} cell_link_t;

endpackage

// ===== sv/min_priority_queue.sv =====
// Min-priority queue of signed 32-bit keys, held sorted in a row of
// compare cells (cell 0 holds the smallest key).
//
// Command channel: func and key_in are taken at a rising edge where start
// is high and busy is low. func selects insert, delete-minimum or
// find-minimum; code 3 does nothing but still returns a beat.
// Result channel: one beat per command, on key_out, status and occupancy,
// marked by done for exactly one cycle. The receiver cannot stall it.
//
// Latency: the result appears the cycle after the command is taken. busy
// is high during that result cycle, so a command is not taken while a
// result beat is shown. In the row, an insert is one broadcast compare
// in each cell and a shift of the larger keys, a delete is a shift of
// the whole row towards cell 0.
//
// Reset (arst_n low) empties the queue at once: every cell valid bit and
// the key count clear, no clearing pass is needed. An insert into a full
// queue is dropped and reported with the full status.
module min_priority_queue (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [1:0]                        func,
	input  logic signed [mpq_pkg::KEY_W-1:0]  key_in,
	output logic                              done,
	output logic signed [mpq_pkg::KEY_W-1:0]  key_out,
	output logic [1:0]                        status,
	output logic [mpq_pkg::OCC_W-1:0]         occupancy
);

	mpq_pkg::cell_ctl_t               ctl;
	mpq_pkg::cell_link_t              links [mpq_pkg::CAPACITY];
	mpq_pkg::cell_link_t              edge_link;
	logic [mpq_pkg::CAPACITY-1:0]     valid_vec;

	logic                             accept;
	logic                             empty;
	logic                             full;
	logic                             done_q;
	logic [mpq_pkg::OCC_W-1:0]        count_q;
	logic [mpq_pkg::OCC_W-1:0]        count_d;
	logic signed [mpq_pkg::KEY_W-1:0] key_out_q;
	logic signed [mpq_pkg::KEY_W-1:0] key_d;
	mpq_pkg::status_t                 status_q;
	mpq_pkg::status_t                 status_d;

	assign accept = start & ~busy;
	assign empty  = ~links[0].valid;
	assign full   = links[mpq_pkg::CAPACITY-1].valid;

	// Neighbour input beyond either end of the row
	assign edge_link = '{valid: 1'b0, val: '0, ins: 1'b0};

	// Row of cells
	for (genvar i = 0; i < mpq_pkg::CAPACITY; i++) begin : g_cell
		mpq_pkg::cell_link_t left_l;
		mpq_pkg::cell_link_t right_l;

		if (i == 0) begin : g_first
			assign left_l = edge_link;
		end else begin : g_mid_l
			assign left_l = links[i-1];
		end

		if (i == mpq_pkg::CAPACITY-1) begin : g_last
			assign right_l = edge_link;
		end else begin : g_mid_r
			assign right_l = links[i+1];
		end

		assign valid_vec[i] = links[i].valid;

		mpq_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.left   (left_l),
			.right  (right_l),
			.link   (links[i])
		);
	end

	// Command decode: cell command, result and new count
	always_comb begin
		ctl.op   = mpq_pkg::CELL_HOLD;
		ctl.key  = key_in;
		key_d    = '0;
		status_d = mpq_pkg::ST_OK;
		count_d  = count_q;
		if (accept) begin
			unique case (mpq_pkg::func_t'(func))
				mpq_pkg::OP_INSERT: begin
					if (full) begin
						status_d = mpq_pkg::ST_FULL;
					end else begin
						ctl.op  = mpq_pkg::CELL_PUSH;
						count_d = count_q + mpq_pkg::OCC_W'(1);
					end
				end
				mpq_pkg::OP_DELMIN: begin
					if (empty) begin
						key_d    = mpq_pkg::EMPTY_DELETE_KEY;
						status_d = mpq_pkg::ST_EMPTY;
					end else begin
						key_d   = links[0].val;
						ctl.op  = mpq_pkg::CELL_POP;
						count_d = count_q - mpq_pkg::OCC_W'(1);
					end
				end
				mpq_pkg::OP_FINDMIN: begin
					if (empty)
						status_d = mpq_pkg::ST_EMPTY;
					else
						key_d = links[0].val;
				end
				default: begin
				end
			endcase
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			done_q  <= accept;
			count_q <= count_d;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			key_out_q <= key_d;
			status_q  <= status_d;
		end
	end

	assign busy      = done_q;
	assign done      = done_q;
	assign key_out   = key_out_q;
	assign status    = status_q;
	assign occupancy = count_q;

	// Checks
	a_count_matches_cells: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == int'(count_q))
		else $error("key count disagrees with cell valid bits");

	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		links[0].valid && links[1].valid |-> !($signed(links[1].val) < $signed(links[0].val)))
		else $error("head cell does not hold the minimum");

	a_full_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == mpq_pkg::ST_FULL |-> occupancy == mpq_pkg::OCC_W'(mpq_pkg::CAPACITY))
		else $error("full status while queue not full");

	a_single_beat: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result beat repeated");

endmodule

// ===== sv/mpq_cell.sv =====
module mpq_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mpq_pkg::cell_ctl_t    ctl,
	input  mpq_pkg::cell_link_t   left,
	input  mpq_pkg::cell_link_t   right,
	output mpq_pkg::cell_link_t   link
);

	logic                            valid_q;
	logic signed [mpq_pkg::KEY_W-1:0] val_q;
	logic                            ins;

	// new key sorts before this entry, or this slot is free
	assign ins = ~valid_q || ($signed(ctl.key) < $signed(val_q));

	assign link.valid = valid_q;
	assign link.val   = val_q;
	assign link.ins   = ins;

	// valid bit: the row stays packed from cell 0 upwards
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (ctl.op)
				mpq_pkg::CELL_PUSH: begin
					if (left.ins)
						valid_q <= left.valid;
					else if (ins)
						valid_q <= 1'b1;
				end
				mpq_pkg::CELL_POP:  valid_q <= right.valid;
				default:            valid_q <= valid_q;
			endcase
		end
	end

	// key: shift right on insert past the slot, shift left on delete
	always_ff @(posedge clk) begin
		case (ctl.op)
			mpq_pkg::CELL_PUSH: begin
				if (left.ins)
					val_q <= left.val;
				else if (ins)
					val_q <= ctl.key;
			end
			mpq_pkg::CELL_POP:  val_q <= right.val;
			default:            val_q <= val_q;
		endcase
	end

endmodule

// ===== test/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_OPS = 1850;
	localparam logic signed [mpq_pkg::KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;
	localparam logic signed [mpq_pkg::KEY_W-1:0] KEY_MIN = 32'sh8000_0000;

	// One result beat as the block reports it
	typedef struct packed {
		logic signed [mpq_pkg::KEY_W-1:0] key;
		mpq_pkg::status_t                 status;
		logic [mpq_pkg::OCC_W-1:0]        occ;
	} mpq_beat_t;

	// Directed stimulus row; want is used only where typed is set
	typedef struct {
		mpq_pkg::func_t                   op;
		logic signed [mpq_pkg::KEY_W-1:0] key;
		bit                               typed;
		mpq_beat_t                        want;
	} dir_row_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             start = 1'b0;
	mpq_pkg::func_t                   func = mpq_pkg::OP_NOP;
	logic signed [mpq_pkg::KEY_W-1:0] key_in = '0;
	logic                             busy;
	logic                             done;
	logic signed [mpq_pkg::KEY_W-1:0] key_out;
	logic [1:0]                       status;
	logic [mpq_pkg::OCC_W-1:0]        occupancy;

	// Side information travelling with the command beat
	bit        item_typed = 1'b0;
	mpq_beat_t item_want = '0;

	// Predictor state and pending expectations
	logic signed [mpq_pkg::KEY_W-1:0] held_keys[$];
	mpq_beat_t                        pending_beats[$];
	int                               err_count = 0;

	min_priority_queue u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.func      (func),
		.key_in    (key_in),
		.done      (done),
		.key_out   (key_out),
		.status    (status),
		.occupancy (occupancy)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Applies one operation to the predictor and returns the beat it implies
	function automatic mpq_beat_t apply_op(mpq_pkg::func_t op,
			logic signed [mpq_pkg::KEY_W-1:0] k);
		mpq_beat_t res;
		int        best;
		res = '{key: '0, status: mpq_pkg::ST_OK, occ: '0};
		best = 0;
		case (op)
			mpq_pkg::OP_INSERT: begin
				if (held_keys.size() >= mpq_pkg::CAPACITY)
					res.status = mpq_pkg::ST_FULL;
				else
					held_keys.push_back(k);
			end
			mpq_pkg::OP_DELMIN, mpq_pkg::OP_FINDMIN: begin
				if (held_keys.size() == 0) begin
					res.status = mpq_pkg::ST_EMPTY;
					if (op == mpq_pkg::OP_DELMIN)
						res.key = mpq_pkg::EMPTY_DELETE_KEY;
				end else begin
					for (int i = 1; i < held_keys.size(); i++)
						if (held_keys[i] < held_keys[best])
							best = i;
					res.key = held_keys[best];
					if (op == mpq_pkg::OP_DELMIN)
						held_keys.delete(best);
				end
			end
			default: ;
		endcase
		res.occ = mpq_pkg::OCC_W'(held_keys.size());
		return res;
	endfunction

	task automatic report_mismatch(string field, logic [mpq_pkg::KEY_W-1:0] got,
			logic [mpq_pkg::KEY_W-1:0] want);
		$display("%0t: %s mismatch: got %h expected %h", $realtime, field, got, want);
		err_count++;
	endtask

	// Check result beats first, then predict for a command taken at this edge
	always @(posedge clk) begin
		mpq_beat_t exp_beat;
		mpq_beat_t model_beat;
		if (arst_n) begin
			if (done === 1'b1) begin
				if (pending_beats.size() == 0) begin
					report_mismatch("done", mpq_pkg::KEY_W'(1), '0);
				end else begin
					exp_beat = pending_beats.pop_front();
					if (key_out !== exp_beat.key)
						report_mismatch("key_out", key_out, exp_beat.key);
					if (status !== exp_beat.status)
						report_mismatch("status", mpq_pkg::KEY_W'(status),
							mpq_pkg::KEY_W'(exp_beat.status));
					if (occupancy !== exp_beat.occ)
						report_mismatch("occupancy", mpq_pkg::KEY_W'(occupancy),
							mpq_pkg::KEY_W'(exp_beat.occ));
				end
			end
			if (start && busy === 1'b0) begin
				model_beat = apply_op(func, key_in);
				pending_beats.push_back(item_typed ? item_want : model_beat);
			end
		end
	end

	// Random gap before a command: mostly short, now and then long
	function automatic int draw_gap(bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 40)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		else
			return $urandom_range(20, 60);
	endfunction

	// Keys: extremes, a narrow band for duplicates, or anything at all
	function automatic logic signed [mpq_pkg::KEY_W-1:0] draw_key();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			case ($urandom_range(0, 5))
				0: return KEY_MIN;
				1: return KEY_MAX;
				2: return 32'sd0;
				3: return -32'sd1;
				4: return KEY_MIN + 1;
				default: return KEY_MAX - 1;
			endcase
		end else if (r < 40)
			return $signed($urandom_range(0, 15)) - 8;
		else
			return $urandom;
	endfunction

	// Hold a command until taken; start stays high across back-to-back beats
	task automatic send_cmd(mpq_pkg::func_t op, logic signed [mpq_pkg::KEY_W-1:0] k,
			bit typed, mpq_beat_t want, int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		func <= op;
		key_in <= k;
		item_typed <= typed;
		item_want <= want;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	// Directed part: empty and boundary keys, ties, unused code
	dir_row_t dir_rows[18] = '{
		'{mpq_pkg::OP_FINDMIN, 32'sd0,  1'b1, '{32'sd0, mpq_pkg::ST_EMPTY, 7'd0}},
		'{mpq_pkg::OP_DELMIN,  32'sd0,  1'b1,
			'{mpq_pkg::EMPTY_DELETE_KEY, mpq_pkg::ST_EMPTY, 7'd0}},
		'{mpq_pkg::OP_INSERT,  KEY_MAX, 1'b1, '{32'sd0, mpq_pkg::ST_OK, 7'd1}},
		'{mpq_pkg::OP_FINDMIN, 32'sd0,  1'b1, '{KEY_MAX, mpq_pkg::ST_OK, 7'd1}},
		'{mpq_pkg::OP_INSERT,  KEY_MIN, 1'b1, '{32'sd0, mpq_pkg::ST_OK, 7'd2}},
		'{mpq_pkg::OP_FINDMIN, -32'sd1, 1'b1, '{KEY_MIN, mpq_pkg::ST_OK, 7'd2}},
		'{mpq_pkg::OP_DELMIN,  KEY_MAX, 1'b1, '{KEY_MIN, mpq_pkg::ST_OK, 7'd1}},
		'{mpq_pkg::OP_DELMIN,  32'sd0,  1'b1, '{KEY_MAX, mpq_pkg::ST_OK, 7'd0}},
		'{mpq_pkg::OP_DELMIN,  -32'sd1, 1'b1,
			'{mpq_pkg::EMPTY_DELETE_KEY, mpq_pkg::ST_EMPTY, 7'd0}},
		'{mpq_pkg::OP_NOP,     -32'sd1, 1'b1, '{32'sd0, mpq_pkg::ST_OK, 7'd0}},
		'{mpq_pkg::OP_INSERT,  32'sd5,  1'b0, '0},
		'{mpq_pkg::OP_INSERT,  32'sd5,  1'b0, '0},
		'{mpq_pkg::OP_INSERT,  -32'sd1, 1'b0, '0},
		'{mpq_pkg::OP_NOP,     32'sd9,  1'b0, '0},
		'{mpq_pkg::OP_DELMIN,  32'sd0,  1'b0, '0},
		'{mpq_pkg::OP_FINDMIN, 32'sd0,  1'b0, '0},
		'{mpq_pkg::OP_DELMIN,  32'sd0,  1'b0, '0},
		'{mpq_pkg::OP_DELMIN,  32'sd0,  1'b0, '0}
	};

	// Main stimulus
	initial begin
		int             sent;
		int             mode;
		int             burst;
		int             r;
		bit             calm;
		mpq_pkg::func_t op;
		sent = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_cmd(dir_rows[i].op, dir_rows[i].key, dir_rows[i].typed,
				dir_rows[i].want, draw_gap(i < 4));

		// Random bursts: filling past full, draining past empty, or mixed
		while (sent < RANDOM_OPS) begin
			mode = $urandom_range(0, 2);
			calm = ($urandom_range(0, 3) == 0);
			burst = $urandom_range(40, 120);
			for (int n = 0; n < burst; n++) begin
				r = $urandom_range(0, 99);
				case (mode)
					0: op = r < 83 ? mpq_pkg::OP_INSERT : r < 93 ? mpq_pkg::OP_DELMIN :
						r < 98 ? mpq_pkg::OP_FINDMIN : mpq_pkg::OP_NOP;
					1: op = r < 15 ? mpq_pkg::OP_INSERT : r < 80 ? mpq_pkg::OP_DELMIN :
						r < 97 ? mpq_pkg::OP_FINDMIN : mpq_pkg::OP_NOP;
					default: op = r < 45 ? mpq_pkg::OP_INSERT :
						r < 75 ? mpq_pkg::OP_DELMIN :
						r < 97 ? mpq_pkg::OP_FINDMIN : mpq_pkg::OP_NOP;
				endcase
				send_cmd(op, draw_key(), 1'b0, '0, draw_gap(calm));
				if (op != mpq_pkg::OP_NOP)
					sent++;
			end
		end
		start <= 1'b0;

		// Drain, then a few quiet cycles for any stray beat
		while (pending_beats.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (err_count == 0)
			$display("min_priority_queue test passed");
		else
			$display("min_priority_queue test failed");
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("min_priority_queue test failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/mpq_pkg.sv
sv/mpq_cell.sv
sv/min_priority_queue.sv
test/tb.sv
